### rtl/rdq_pkg.sv
// rdq_pkg: shared constants, codes and types for the reversible deque engine
`default_nettype none
package rdq_pkg;
    localparam int unsigned DEPTH = 1024;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned OW = AW + 1;
    localparam int unsigned VW = 16;

    typedef logic [AW-1:0] t_addr;
    typedef logic [OW-1:0] t_occ;
    typedef logic [VW-1:0] t_value;

    typedef enum logic [2:0] {
        KIND_CLEAR   = 3'd0,
        KIND_PUSH    = 3'd1,
        KIND_REVERSE = 3'd2,
        KIND_DELETE  = 3'd3,
        KIND_DRAIN   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_ELEMENT    = 2'd0,
        ST_DEL_EMPTY  = 2'd1,
        ST_EMPTY_LIST = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    localparam t_occ DEPTH_OCC = OW'(DEPTH);

    // ring index: sum of an index below depth and a count up to depth, folded once
    function automatic t_addr wrap_add(input t_addr base, input t_occ offs);
        logic [OW:0] sum;
        sum = {2'b00, base} + {1'b0, offs};
        if (sum >= {1'b0, DEPTH_OCC}) begin
            sum = sum - {1'b0, DEPTH_OCC};
        end
        return sum[AW-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/reversible_deque_engine_core.sv
// reversible_deque_engine_core: ring-buffer deque with a reverse flag and sticky delete error
// Commands arrive one per stream transaction. Clear, push, reverse and delete finish in the
// cycle they are accepted; a drain that finds an element starts an element memory read and
// waits in S_READ until the output register is free to take the read data. Results that come
// straight from the pointers (overflow, delete on empty, empty list) are loaded into the
// output register at acceptance. A new command is taken whenever the engine is not waiting
// on a memory read and the output register is empty or being emptied in the same cycle.
// The element memory needs no clearing after reset: only pushed entries are ever read.
`default_nettype none
module reversible_deque_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // value[15:0]
    input  wire logic [2:0]  i_s_tuser,  // kind[2:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,  // element[15:0]
    output logic      [1:0]  o_m_tuser,  // status[1:0]
    output logic             o_m_tlast
);
    import rdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state  r_state, n_state;
    t_addr   r_head, n_head;
    t_occ    r_occ, n_occ;
    logic    r_rev, n_rev;
    logic    r_failed, n_failed;
    logic    r_pend_last, n_pend_last;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_value  r_out_elem, n_out_elem;
    logic    r_out_last, n_out_last;

    logic    slot_free;
    logic    s_accept;
    t_kind   in_kind;
    t_value  in_value;
    logic    wr_en;
    t_addr   wr_addr;
    logic    rd_en;
    t_addr   rd_addr;
    t_value  rd_data;
    t_addr   back_addr;
    t_addr   tail_addr;

    assign in_kind    = t_kind'(i_s_tuser);
    assign in_value   = i_s_tdata;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && slot_free;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign tail_addr = wrap_add(r_head, r_occ);
    assign back_addr = wrap_add(r_head, r_occ - OW'(1));

    rdq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_occ        = r_occ;
        n_rev        = r_rev;
        n_failed     = r_failed;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = tail_addr;
        rd_en        = 1'b0;
        rd_addr      = r_rev ? back_addr : r_head;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (in_kind)
                        KIND_CLEAR: begin
                            n_head   = '0;
                            n_occ    = '0;
                            n_rev    = 1'b0;
                            n_failed = 1'b0;
                        end
                        KIND_PUSH: begin
                            if (r_occ >= DEPTH_OCC) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_OVERFLOW;
                                n_out_elem   = '0;
                                n_out_last   = 1'b0;
                            end else begin
                                wr_en = 1'b1;
                                n_occ = r_occ + OW'(1);
                            end
                        end
                        KIND_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        KIND_DELETE, KIND_DRAIN: begin
                            if (!r_failed) begin
                                if (r_occ == '0) begin
                                    n_out_valid  = 1'b1;
                                    n_out_elem   = '0;
                                    n_out_last   = 1'b0;
                                    if (in_kind == KIND_DELETE) begin
                                        n_out_status = ST_DEL_EMPTY;
                                        n_failed     = 1'b1;
                                    end else begin
                                        n_out_status = ST_EMPTY_LIST;
                                    end
                                end else begin
                                    n_occ = r_occ - OW'(1);
                                    if (!r_rev) begin
                                        n_head = wrap_add(r_head, OW'(1));
                                    end
                                    if (in_kind == KIND_DRAIN) begin
                                        rd_en       = 1'b1;
                                        n_pend_last = (r_occ == OW'(1));
                                        n_state     = S_READ;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ELEMENT;
                    n_out_elem   = rd_data;
                    n_out_last   = r_pend_last;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_rev       <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_rev       <= n_rev;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last  <= n_pend_last;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_elem;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_OCC)
        else $error("occupancy above depth");

    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !o_s_tready)
        else $error("command taken during element read");

    a_read_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_READ) |-> $past(s_accept) && $past(in_kind == KIND_DRAIN))
        else $error("element read without a drain");

    a_failed_blocks_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed && s_accept && in_kind == KIND_DELETE |=> $stable(r_occ))
        else $error("delete changed occupancy while failed");
`endif
endmodule
`default_nettype wire

### rtl/rdq_ram.sv
// rdq_ram: simple dual-port synchronous ram, one write and one registered read port
`default_nettype none
module rdq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

### verif/reversible_deque_engine_core_checker.sv
`timescale 1ns / 1ps
// reversible_deque_engine_core_checker: deque result predictor and stream scoreboard
module reversible_deque_engine_core_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,  // value[15:0]
    input  wire logic [2:0]  i_s_tuser,  // kind[2:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,  // element[15:0]
    input  wire logic [1:0]  i_m_tuser,  // status[1:0]
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    import rdq_pkg::*;

    localparam int unsigned EXP_SLOTS = 16;

    typedef struct packed {
        t_status status;
        t_value  element;
        logic    last;
    } t_deque_result;

    t_value        ring_mem [DEPTH];
    int unsigned   ring_head;
    int unsigned   ring_count;
    logic          dir_reversed;
    logic          del_failed;
    t_deque_result exp_fifo [EXP_SLOTS];
    int unsigned   exp_wr = 0;
    int unsigned   exp_rd = 0;
    int            fail_total = 0;
    int            checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = int'(exp_wr - exp_rd);
    assign o_checked    = checked_total;

    task automatic exp_put(input t_deque_result res);
        if (exp_wr - exp_rd >= EXP_SLOTS) begin
            $display("%0t: expected result buffer overrun", $realtime);
            fail_total++;
        end else begin
            exp_fifo[exp_wr % EXP_SLOTS] = res;
            exp_wr++;
        end
    endtask

    task automatic apply_command(input logic [2:0] kind, input t_value value);
        t_deque_result res;
        int unsigned   idx;
        res = '{status: ST_ELEMENT, element: '0, last: 1'b0};
        case (kind)
            KIND_CLEAR: begin
                ring_head    = 0;
                ring_count   = 0;
                dir_reversed = 1'b0;
                del_failed   = 1'b0;
            end
            KIND_PUSH: begin
                if (ring_count >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                    exp_put(res);
                end else begin
                    ring_mem[(ring_head + ring_count) % DEPTH] = value;
                    ring_count++;
                end
            end
            KIND_REVERSE: begin
                dir_reversed = !dir_reversed;
            end
            KIND_DELETE, KIND_DRAIN: begin
                // sticky error blocks every removal until a clear
                if (!del_failed) begin
                    if (ring_count == 0) begin
                        if (kind == KIND_DELETE) begin
                            del_failed = 1'b1;
                            res.status = ST_DEL_EMPTY;
                        end else begin
                            res.status = ST_EMPTY_LIST;
                        end
                        exp_put(res);
                    end else begin
                        if (dir_reversed) begin
                            idx = (ring_head + ring_count - 1) % DEPTH;
                        end else begin
                            idx = ring_head;
                            ring_head = (ring_head + 1) % DEPTH;
                        end
                        ring_count--;
                        if (kind == KIND_DRAIN) begin
                            res.element = ring_mem[idx];
                            res.last    = (ring_count == 0);
                            exp_put(res);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input logic [1:0] status, input t_value element,
                                input logic last);
        t_deque_result exp_res;
        if (exp_wr == exp_rd) begin
            $display("%0t: unexpected result status %0d element %h last %b",
                     $realtime, status, element, last);
            fail_total++;
        end else begin
            exp_res = exp_fifo[exp_rd % EXP_SLOTS];
            exp_rd++;
            checked_total++;
            if (exp_res.status != status || exp_res.element != element ||
                exp_res.last != last) begin
                $display("%0t: mismatch expected status %0d element %h last %b,",
                         $realtime, exp_res.status, exp_res.element, exp_res.last);
                $display("    got status %0d element %h last %b", status, element, last);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_head    = 0;
            ring_count   = 0;
            dir_reversed = 1'b0;
            del_failed   = 1'b0;
            exp_wr       = 0;
            exp_rd       = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result(i_m_tuser, i_m_tdata, i_m_tlast);
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_command(i_s_tuser, i_s_tdata);
            end
        end
    end
endmodule

### verif/reversible_deque_engine_core_tb.sv
`timescale 1ns / 1ps
// reversible_deque_engine_core_tb: command stimulus, receiver stalls and verdict for the deque
module reversible_deque_engine_core_tb;
    import rdq_pkg::*;

    localparam int         STALL_LIMIT      = 4000;
    localparam int         RX_HOLD_CYCLES   = 300;
    localparam int         RANDOM_PER_PHASE = 60;
    localparam int         SETTLE_CYCLES    = 20;
    localparam logic [2:0] KIND_SPARE_LO    = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI    = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;   // value[15:0]
    logic [2:0]  s_tuser = '0;   // kind[2:0]
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;        // element[15:0]
    logic [1:0]  m_tuser;        // status[1:0]
    logic        m_tlast;

    int   fail_count;
    int   pending;
    int   checked;
    int   src_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic hold_start = 1'b0;
    logic hold_finished = 1'b0;
    int   shadow_count = 0;
    logic shadow_failed = 1'b0;
    int   sent_total = 0;
    int   sent_effective = 0;
    int   idle_cycles = 0;

    always #1 clk = ~clk;

    reversible_deque_engine_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    reversible_deque_engine_core_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // rough occupancy and error tracking, only to steer the random mix
    task automatic send_cmd(input logic [2:0] kind, input t_value value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        sent_total++;
        case (kind)
            KIND_CLEAR: begin
                shadow_count  = 0;
                shadow_failed = 1'b0;
                sent_effective++;
            end
            KIND_PUSH: begin
                if (shadow_count < DEPTH) shadow_count++;
                sent_effective++;
            end
            KIND_REVERSE: begin
                sent_effective++;
            end
            KIND_DELETE, KIND_DRAIN: begin
                if (!shadow_failed) begin
                    sent_effective++;
                    if (shadow_count > 0) shadow_count--;
                    else if (kind == KIND_DELETE) shadow_failed = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic run_random(input int target);
        int         done_cnt;
        int         eff_prev;
        int         r;
        logic [2:0] kind;
        done_cnt = 0;
        while (done_cnt < target) begin
            r = $urandom_range(99);
            if (shadow_failed && r < 50) kind = KIND_CLEAR;
            else if (r < 2) kind = KIND_CLEAR;
            else if (r < 5) kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
            else if (r < 50) kind = KIND_PUSH;
            else if (r < 60) kind = KIND_REVERSE;
            else if (r < 70) kind = KIND_DELETE;
            else kind = KIND_DRAIN;
            eff_prev = sent_effective;
            send_cmd(kind, t_value'($urandom));
            if (sent_effective != eff_prev) done_cnt++;
        end
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_start && !hold_finished) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_finished = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, delete error, removals ignored while the error is sticky
        send_cmd(KIND_DRAIN, 16'h1111);
        send_cmd(KIND_DELETE, 16'h2222);
        send_cmd(KIND_DELETE, 16'h3333);
        send_cmd(KIND_DRAIN, 16'h4444);
        send_cmd(KIND_REVERSE, 16'h0000);
        send_cmd(KIND_PUSH, 16'h0000);
        send_cmd(KIND_PUSH, 16'hFFFF);
        // clear drops the elements and both flags
        send_cmd(KIND_CLEAR, 16'hFFFF);
        send_cmd(KIND_DRAIN, 16'h0000);
        send_cmd(KIND_PUSH, 16'h0000);
        send_cmd(KIND_PUSH, 16'hFFFF);
        send_cmd(KIND_PUSH, 16'hA5A5);
        send_cmd(KIND_PUSH, 16'h5A5A);
        send_cmd(KIND_DRAIN, 16'h0000);
        send_cmd(KIND_REVERSE, 16'h0000);
        send_cmd(KIND_DRAIN, 16'h0000);
        send_cmd(KIND_DELETE, 16'h0000);
        send_cmd(KIND_DRAIN, 16'h0000);
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) send_cmd(3'(k), 16'hDEAD);
        send_cmd(KIND_REVERSE, 16'h0000);
        send_cmd(KIND_PUSH, 16'h1234);
        send_cmd(KIND_DELETE, 16'h0000);
        send_cmd(KIND_DRAIN, 16'h0000);

        // long receiver hold-off while drains keep coming
        hold_start <= 1'b1;
        repeat (8) send_cmd(KIND_PUSH, t_value'($urandom));
        repeat (12) send_cmd(KIND_DRAIN, t_value'($urandom));

        // fill to depth, overflow, then wrap the tail past the end of the ring
        send_cmd(KIND_CLEAR, 16'h0000);
        repeat (DEPTH + 3) send_cmd(KIND_PUSH, t_value'($urandom));
        repeat (100) send_cmd(KIND_DRAIN, t_value'($urandom));
        repeat (60) send_cmd(KIND_PUSH, t_value'($urandom));
        send_cmd(KIND_REVERSE, 16'h0000);
        repeat (80) send_cmd(KIND_DRAIN, t_value'($urandom));
        repeat (20) send_cmd(KIND_DELETE, t_value'($urandom));
        send_cmd(KIND_REVERSE, 16'h0000);
        repeat (20) send_cmd(KIND_DRAIN, t_value'($urandom));
        send_cmd(KIND_CLEAR, 16'h0000);

        run_random(RANDOM_PER_PHASE);
        src_idle_pct = 81;
        rx_stall_pct = 0;
        run_random(RANDOM_PER_PHASE);
        src_idle_pct = 0;
        rx_stall_pct = 81;
        run_random(RANDOM_PER_PHASE);
        src_idle_pct = 19;
        rx_stall_pct = 19;
        run_random(RANDOM_PER_PHASE);

        s_tvalid <= 1'b0;
        rx_stall_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d commands: error and clear cases, fill with overflow and wrap,",
                 sent_total);
        $display("receiver hold-off and four idle profiles; %0d results compared", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
